### hw/rtl/bers_pkg.sv
// Shared types and constants for the batch elevator request scheduler.
`default_nettype none

package bers_pkg;

  localparam int DEPTH   = 64;
  localparam int LOC_W   = 30;
  localparam int RID_W   = 30;
  localparam int ENTRY_W = LOC_W + RID_W;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  typedef logic [LOC_W-1:0]   loc_t;
  typedef logic [RID_W-1:0]   rid_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_MOVE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/bers_if.sv
// Request and served-result channel interfaces.
`default_nettype none

interface bers_req_if;
  logic          valid;
  logic          ready;
  logic          func;
  bers_pkg::loc_t location;
  bers_pkg::rid_t requester;

  modport source (output valid, output func, output location, output requester, input ready);
  modport sink   (input valid, input func, input location, input requester, output ready);
endinterface

interface bers_srv_if;
  logic          valid;
  logic          ready;
  bers_pkg::rid_t served_requester;
  bers_pkg::loc_t served_location;
  logic          last;

  modport source (output valid, output served_requester, output served_location,
                  output last, input ready);
  modport sink   (input valid, input served_requester, input served_location,
                  input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/bers_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bers_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/batch_elevator_request_scheduler.sv
// SCAN request scheduler top level: request table, sweep sequencer, result register.
// Inserts are accepted back to back while idle. A drain serves its pending requests one
// at a time: each result scans all pending entries, one table read and one compare per
// cycle through a single comparator, then the tail entry fills the served slot once the
// result register is free. An empty drain only flips the sweep. Not ready while a drain runs.
// Synchronous reset empties the table and sets the first sweep to descend.
`default_nettype none

module batch_elevator_request_scheduler (
  input  wire logic   clk,
  input  wire logic   rst,
  bers_req_if.sink    req,
  bers_srv_if.source  srv
);

  bers_pkg::state_t state, state_next;
  bers_pkg::cnt_t   count;
  bers_pkg::cnt_t   tail_cnt;
  bers_pkg::addr_t  tail_addr;
  logic             ascending;

  bers_pkg::addr_t  scan_idx;
  bers_pkg::addr_t  rd_idx;
  logic             rd_vld;
  bers_pkg::loc_t   best_loc;
  bers_pkg::rid_t   best_rid;
  bers_pkg::addr_t  best_slot;

  logic             out_valid;
  bers_pkg::loc_t   out_loc;
  bers_pkg::rid_t   out_rid;
  logic             out_last;

  logic             ram_we;
  bers_pkg::addr_t  ram_waddr;
  bers_pkg::entry_t ram_wdata;
  bers_pkg::addr_t  ram_raddr;
  bers_pkg::entry_t ram_rdata;
  bers_pkg::loc_t   rd_loc;
  bers_pkg::rid_t   rd_rid;

  logic             accept;
  logic             insert_ok;
  logic             scan_last;
  logic             move_go;
  bers_pkg::loc_t   cmp_a;
  bers_pkg::loc_t   cmp_b;
  logic             take;

  bers_ram #(
    .WIDTH (bers_pkg::ENTRY_W),
    .DEPTH (bers_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready            = (state == bers_pkg::S_IDLE);
  assign accept               = req.valid && req.ready;
  assign insert_ok            = accept && (req.func == bers_pkg::FUNC_INSERT) &&
                                (count < bers_pkg::CNT_W'(bers_pkg::DEPTH));
  assign tail_cnt             = count - bers_pkg::CNT_W'(1);
  assign tail_addr            = tail_cnt[bers_pkg::ADDR_W-1:0];
  assign scan_last            = (bers_pkg::CNT_W'(scan_idx) == tail_cnt);
  assign move_go              = (state == bers_pkg::S_MOVE) && (!out_valid || srv.ready);
  assign rd_loc               = ram_rdata[bers_pkg::ENTRY_W-1:bers_pkg::RID_W];
  assign rd_rid               = ram_rdata[bers_pkg::RID_W-1:0];

  // shared comparator, operands swapped by sweep direction
  assign cmp_a = ascending ? rd_loc : best_loc;
  assign cmp_b = ascending ? best_loc : rd_loc;
  assign take  = (rd_idx == '0) || (cmp_a < cmp_b);

  assign srv.valid            = out_valid;
  assign srv.served_location  = out_loc;
  assign srv.served_requester = out_rid;
  assign srv.last             = out_last;

  always_comb begin
    state_next = state;
    unique case (state)
      bers_pkg::S_IDLE: begin
        if (accept && (req.func == bers_pkg::FUNC_DRAIN) && (count != '0)) begin
          state_next = bers_pkg::S_SCAN;
        end
      end
      bers_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = bers_pkg::S_LAST;
        end
      end
      bers_pkg::S_LAST: begin
        state_next = bers_pkg::S_MOVE;
      end
      bers_pkg::S_MOVE: begin
        if (move_go) begin
          state_next = (tail_cnt == '0) ? bers_pkg::S_IDLE : bers_pkg::S_SCAN;
        end
      end
      default: state_next = bers_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[bers_pkg::ADDR_W-1:0];
    ram_wdata = {req.location, req.requester};
    ram_raddr = scan_idx;
    unique case (state)
      bers_pkg::S_IDLE: begin
        ram_we = insert_ok;
      end
      bers_pkg::S_SCAN: begin
        ram_raddr = scan_idx;
      end
      bers_pkg::S_LAST: begin
        ram_raddr = tail_addr;
      end
      bers_pkg::S_MOVE: begin
        // tail entry fills the served slot
        ram_raddr = tail_addr;
        ram_we    = move_go;
        ram_waddr = best_slot;
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bers_pkg::S_IDLE;
      count     <= '0;
      ascending <= 1'b0;
      scan_idx  <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == bers_pkg::S_SCAN);
      if (state == bers_pkg::S_SCAN) begin
        scan_idx <= scan_idx + bers_pkg::ADDR_W'(1);
      end else begin
        scan_idx <= '0;
      end
      if (insert_ok) begin
        count <= count + bers_pkg::CNT_W'(1);
      end
      if (accept && (req.func == bers_pkg::FUNC_DRAIN) && (count == '0)) begin
        ascending <= ~ascending;
      end
      if (move_go) begin
        count <= tail_cnt;
        if (tail_cnt == '0) begin
          ascending <= ~ascending;
        end
      end
      if (move_go) begin
        out_valid <= 1'b1;
      end else if (srv.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (rd_vld && take) begin
      best_loc  <= rd_loc;
      best_rid  <= rd_rid;
      best_slot <= rd_idx;
    end
    if (move_go) begin
      out_loc  <= best_loc;
      out_rid  <= best_rid;
      out_last <= (tail_cnt == '0);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bers_pkg::CNT_W'(bers_pkg::DEPTH))
    else $error("pending count above table depth");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != bers_pkg::S_IDLE) |-> (count != '0))
    else $error("sweep running on empty table");

  a_slot_valid: assert property (@(posedge clk) disable iff (rst)
    move_go |-> (bers_pkg::CNT_W'(best_slot) < count))
    else $error("served slot outside pending entries");

  a_flip_at_end: assert property (@(posedge clk) disable iff (rst)
    (move_go && (tail_cnt == '0)) |=> (ascending != $past(ascending)))
    else $error("direction not flipped after final transfer of drain");
`endif

endmodule

`default_nettype wire

### test/tb_batch_elevator_request_scheduler.sv
// Self-checking testbench for the batch elevator request scheduler (SCAN order, random flow control).
module tb_batch_elevator_request_scheduler;

  localparam bers_pkg::loc_t LOC_MAX = {bers_pkg::LOC_W{1'b1}};
  localparam bers_pkg::rid_t RID_MAX = {bers_pkg::RID_W{1'b1}};

  typedef struct packed {
    bers_pkg::rid_t requester;
    bers_pkg::loc_t location;
    logic last;
  } served_t;

  logic clk = 1'b0;
  logic rst;

  bers_req_if req_ch();
  bers_srv_if srv_ch();

  batch_elevator_request_scheduler dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .srv (srv_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the request table and sweep direction.
  bers_pkg::loc_t shadow_loc [bers_pkg::DEPTH];
  bers_pkg::rid_t shadow_rid [bers_pkg::DEPTH];
  int      shadow_count = 0;
  bit      shadow_ascending = 1'b0;
  served_t serve_order_q[$];

  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;

  // Receiver flow control.
  logic rx_ready = 1'b0;
  logic rx_hold = 1'b0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;

  assign srv_ch.ready = rx_ready;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(16, 96);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (rx_hold) begin
      rx_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: rx_ready <= 1'b1;
        1: rx_ready <= ($urandom_range(0, 1) == 0);
        2: rx_ready <= ($urandom_range(0, 3) == 0);
        default: rx_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  function automatic void schedule_item(logic f, bers_pkg::loc_t l, bers_pkg::rid_t r);
    int best;
    int tail;
    served_t s;
    if (f == bers_pkg::FUNC_INSERT) begin
      if (shadow_count < bers_pkg::DEPTH) begin
        shadow_loc[shadow_count] = l;
        shadow_rid[shadow_count] = r;
        shadow_count++;
      end
    end else begin
      while (shadow_count > 0) begin
        best = 0;
        for (int i = 1; i < shadow_count; i++) begin
          if (shadow_ascending ? (shadow_loc[i] < shadow_loc[best])
                               : (shadow_loc[i] > shadow_loc[best]))
            best = i;
        end
        tail = shadow_count - 1;
        s.requester = shadow_rid[best];
        s.location  = shadow_loc[best];
        s.last      = (tail == 0);
        shadow_loc[best] = shadow_loc[tail];
        shadow_rid[best] = shadow_rid[tail];
        shadow_count = tail;
        serve_order_q.push_back(s);
      end
      shadow_ascending = ~shadow_ascending;
    end
  endfunction

  // Result checker and input monitor.
  always @(posedge clk) begin
    served_t exp_s;
    if (!rst) begin
      if (srv_ch.valid && srv_ch.ready) begin
        if (serve_order_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: rid=%h loc=%h last=%b",
                     srv_ch.served_requester, srv_ch.served_location, srv_ch.last);
        end else begin
          exp_s = serve_order_q.pop_front();
          if (srv_ch.served_requester !== exp_s.requester ||
              srv_ch.served_location !== exp_s.location ||
              srv_ch.last !== exp_s.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected rid=%h loc=%h last=%b, got rid=%h loc=%h last=%b",
                       exp_s.requester, exp_s.location, exp_s.last,
                       srv_ch.served_requester, srv_ch.served_location, srv_ch.last);
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        schedule_item(req_ch.func, req_ch.location, req_ch.requester);
    end
  end

  task automatic send_item(logic f, bers_pkg::loc_t l, bers_pkg::rid_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.func      <= f;
    req_ch.location  <= l;
    req_ch.requester <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (serve_order_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic hold_results(int cycles);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
  endtask

  function automatic bers_pkg::loc_t pick_loc(int mode);
    case (mode)
      0: pick_loc = bers_pkg::loc_t'($urandom());
      1: pick_loc = bers_pkg::loc_t'($urandom_range(0, 7));
      default: begin
        case ($urandom_range(0, 3))
          0: pick_loc = '0;
          1: pick_loc = LOC_MAX;
          2: pick_loc = LOC_MAX - 1;
          default: pick_loc = bers_pkg::loc_t'(1);
        endcase
      end
    endcase
  endfunction

  task automatic test_directed();
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
    send_item(bers_pkg::FUNC_INSERT, LOC_MAX, '0);
    send_item(bers_pkg::FUNC_INSERT, '0, RID_MAX);
    send_item(bers_pkg::FUNC_INSERT, bers_pkg::loc_t'(5), bers_pkg::rid_t'(30'h2AAAAAAA));
    send_item(bers_pkg::FUNC_INSERT, bers_pkg::loc_t'(5), bers_pkg::rid_t'(30'h15555555));
    send_item(bers_pkg::FUNC_INSERT, LOC_MAX, bers_pkg::rid_t'(1));
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
    send_item(bers_pkg::FUNC_INSERT, bers_pkg::loc_t'(30'h15555555),
              bers_pkg::rid_t'(30'h2AAAAAAA));
    send_item(bers_pkg::FUNC_DRAIN, LOC_MAX, RID_MAX);
    for (int i = 0; i < 4; i++)
      send_item(bers_pkg::FUNC_INSERT, bers_pkg::loc_t'(30'h2AAAAAAA), bers_pkg::rid_t'(i));
    send_item(bers_pkg::FUNC_INSERT, LOC_MAX, RID_MAX);
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
    send_item(bers_pkg::FUNC_INSERT, '0, '0);
    send_item(bers_pkg::FUNC_INSERT, '0, bers_pkg::rid_t'(7));
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
    wait_drained();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < bers_pkg::DEPTH + 3; i++)
      send_item(bers_pkg::FUNC_INSERT, pick_loc($urandom_range(0, 2)),
                bers_pkg::rid_t'($urandom()));
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_results(400);
    for (int i = 0; i < 10; i++)
      send_item(bers_pkg::FUNC_INSERT, pick_loc(0), bers_pkg::rid_t'($urandom()));
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
    for (int i = 0; i < 5; i++)
      send_item(bers_pkg::FUNC_INSERT, pick_loc(1), bers_pkg::rid_t'($urandom()));
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
    wait_drained();
  endtask

  task automatic test_random();
    int n;
    int mode;
    int start;
    start = items_sent;
    while (items_sent - start < 50) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++)
        send_item(bers_pkg::FUNC_INSERT, pick_loc(mode), bers_pkg::rid_t'($urandom()));
      if ($urandom_range(0, 6) != 0)
        send_item(bers_pkg::FUNC_DRAIN, bers_pkg::loc_t'($urandom()),
                  bers_pkg::rid_t'($urandom()));
      if ($urandom_range(0, 9) == 0)
        send_item(bers_pkg::FUNC_DRAIN, bers_pkg::loc_t'($urandom()),
                  bers_pkg::rid_t'($urandom()));
    end
    send_item(bers_pkg::FUNC_DRAIN, '0, '0);
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.func      = bers_pkg::FUNC_INSERT;
    req_ch.location  = '0;
    req_ch.requester = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && serve_order_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #24000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### batch_elevator_request_scheduler.f
hw/rtl/bers_pkg.sv
hw/rtl/bers_if.sv
hw/rtl/bers_ram.sv
hw/rtl/batch_elevator_request_scheduler.sv
test/tb_batch_elevator_request_scheduler.sv
